>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// The consequent must hold at the same edge as the antecedent.
`define ASSERT_IMPLIES(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold at the edge after the antecedent.
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/lrusd_pkg.sv
`default_nettype none

package lrusd_pkg;

   // Stack geometry.
   localparam int STACK_DEPTH = 256;
   localparam int STACK_AW    = $clog2(STACK_DEPTH);
   localparam int FILL_W      = STACK_AW + 1;

   // Histogram geometry, fixed by the 8-bit bin index.
   localparam int HIST_BINS = 256;
   localparam int HIST_AW   = 8;

   localparam logic [63:0] HIGH_ONES = 64'hFFFF_FFFF_0000_0000;
   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
   localparam logic [3:0]  LINE_SHIFT_RESET = 4'd6;

   // Transaction opcodes.
   localparam logic [1:0] OP_ACCESS = 2'd0;
   localparam logic [1:0] OP_RETIRE = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_EXCLUDE    = 2'd0;
   localparam logic [1:0] CSR_LINE_SHIFT = 2'd1;
   localparam logic [1:0] CSR_CODE_BASE  = 2'd2;
   localparam logic [1:0] CSR_CODE_SIZE  = 2'd3;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [63:0] address;
      logic [7:0]  bin_index;
   } lrusd_req_type;

   typedef struct packed {
      logic [7:0]  distance;
      logic        was_hit;
      logic        was_cold;
      logic        was_skipped;
      logic [31:0] bin_count;
      logic [31:0] cold_total;
      logic [31:0] access_total;
      logic [31:0] retired_total;
      logic [7:0]  deepest_hit;
   } lrusd_rsp_type;

   // Command from the controller to the stack engine.
   typedef struct packed {
      logic        start;
      logic [63:0] line;
   } lrusd_search_cmd_type;

   // Status from the stack engine; valid while done is high.
   typedef struct packed {
      logic              done;
      logic              hit;
      logic [FILL_W-1:0] depth;
   } lrusd_search_sts_type;

   typedef enum logic [1:0] {
      STK_IDLE,
      STK_SCAN,
      STK_TAIL
   } lrusd_stk_state_type;

   typedef enum logic [2:0] {
      TOP_IDLE,
      TOP_DECODE,
      TOP_SEARCH,
      TOP_HREAD,
      TOP_RESP
   } lrusd_top_state_type;

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      return (v == COUNT_MAX) ? v : v + 32'd1;
   endfunction

   // Depths beyond the last histogram bin are reported as the last bin.
   function automatic logic [7:0] clamp_dist(input logic [FILL_W-1:0] d);
      logic [31:0] dx;
      dx = 32'(d);
      return (dx > 32'd255) ? 8'hFF : dx[7:0];
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/lrusd_stack.sv
`default_nettype none

`include "assert_macros.svh"

// Bounded LRU stack held in one memory. A single pass from the top reads each
// entry, writes the carried line in its place and carries the old entry down,
// stopping at the matching line or at the fill level.
module lrusd_stack
   import lrusd_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lrusd_search_cmd_type cmd,
   output lrusd_search_sts_type      sts
);

   lrusd_stk_state_type state_ff, state_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [FILL_W-1:0]   idx_ff, idx_in;
   logic [63:0]         line_ff;
   logic [63:0]         carry_ff;

   logic [63:0]         stack_mem [STACK_DEPTH];
   logic [63:0]         rd_data_ff;
   logic                rd_en;
   logic [STACK_AW-1:0] rd_addr;
   logic                wr_en;
   logic [STACK_AW-1:0] wr_addr;
   logic [63:0]         wr_data;

   logic                match;
   logic                last;
   logic                full;
   logic [FILL_W-1:0]   idx_next;

   assign match    = (rd_data_ff == line_ff);
   assign idx_next = idx_ff + FILL_W'(1);
   assign last     = (idx_next == fill_ff);
   assign full     = (fill_ff == FILL_W'(STACK_DEPTH));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         STK_IDLE: begin
            if (cmd.start) begin
               state_in = (fill_ff == '0) ? STK_TAIL : STK_SCAN;
            end
         end
         STK_SCAN: begin
            if (match) begin
               state_in = STK_IDLE;
            end else if (last) begin
               state_in = STK_TAIL;
            end
         end
         STK_TAIL: state_in = STK_IDLE;
         default:  state_in = STK_IDLE;
      endcase
   end

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      wr_en   = 1'b0;
      wr_addr = idx_ff[STACK_AW-1:0];
      wr_data = carry_ff;
      idx_in  = idx_ff;
      fill_in = fill_ff;
      sts     = '0;
      unique case (state_ff)
         STK_IDLE: begin
            rd_en  = cmd.start;
            idx_in = '0;
         end
         STK_SCAN: begin
            wr_en     = 1'b1;
            rd_en     = !match && !last;
            rd_addr   = idx_next[STACK_AW-1:0];
            idx_in    = idx_next;
            sts.done  = match;
            sts.hit   = match;
            sts.depth = idx_ff;
         end
         STK_TAIL: begin
            // A miss on a full stack simply lets the carried bottom line fall off.
            wr_en    = !full;
            wr_addr  = fill_ff[STACK_AW-1:0];
            fill_in  = full ? fill_ff : fill_ff + FILL_W'(1);
            sts.done = 1'b1;
         end
         default: begin
            idx_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STK_IDLE;
         fill_ff  <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == STK_IDLE && cmd.start) begin
         line_ff  <= cmd.line;
         carry_ff <= cmd.line;
      end else if (state_ff == STK_SCAN) begin
         carry_ff <= rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= stack_mem[rd_addr];
      end
   end

   `ASSERT_ALWAYS(a_fill_bound, clock, reset, fill_ff <= FILL_W'(STACK_DEPTH), "stack overfilled")
   `ASSERT_IMPLIES(a_scan_in_range, clock, reset, state_ff == STK_SCAN, idx_ff < fill_ff, "scan past fill")
   `ASSERT_NEXT(a_fill_only_on_tail, clock, reset, state_ff != STK_TAIL, $stable(fill_ff), "fill moved outside tail")

endmodule

`default_nettype wire

>>> rtl/core/lru_stack_distance_profiler.sv
// LRU stack-distance profiler.
// Transactions enter on req_valid/req_stall with an opcode: a memory access,
// a retire tick or a histogram bin read. Every transaction returns exactly one
// result on rsp_valid/rsp_stall, carrying the running totals after it.
// An access is reduced to its line address and searched from the top of an
// LRU stack; a hit bins its depth, a miss counts as cold, and the line moves to
// the top. Configuration is written on csr_we/csr_index/csr_wdata; the user
// must write it only while idle, as the block itself does not enforce this.
// A hit passes through decode, the stack search (one stack entry per cycle),
// a histogram read and write-back, and the response state; a miss skips the
// histogram step. A skipped access, a retire tick or an unknown opcode goes
// from decode to the response state, and a bin read adds a histogram read.
// Requests are taken only once a result is loaded; req_stall is low only while idle.
// Synchronous reset empties the stack, clears all counters and histogram bins
// (through per-bin valid bits) and restores the register defaults.
// If the receiver stalls, the result waits in the output register and the
// next transaction can be accepted and processed; its result waits until the
// output register has been taken.
`default_nettype none

`include "assert_macros.svh"

module lru_stack_distance_profiler
   import lrusd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire lrusd_req_type req_data,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output lrusd_rsp_type      rsp_data,
   input  wire logic          csr_we,
   input  wire logic [1:0]    csr_index,
   input  wire logic [31:0]   csr_wdata
);

   // Configuration registers.
   logic        exclude_ff;
   logic [3:0]  shift_ff;
   logic [31:0] base_ff;
   logic [31:0] size_ff;

   lrusd_top_state_type state_ff, state_in;
   lrusd_req_type       req_ff;

   // Per-transaction result fields.
   logic [7:0]  dist_ff;
   logic        hit_ff;
   logic        cold_ff;
   logic        skip_ff;
   logic [31:0] count_ff;

   // Running totals.
   logic [31:0] cold_cnt_ff;
   logic [31:0] access_cnt_ff;
   logic [31:0] retire_cnt_ff;
   logic [7:0]  max_depth_ff;

   // Output register.
   lrusd_rsp_type rsp_ff;
   logic          rsp_valid_ff;
   logic          rsp_load;

   // Histogram memory; a bin whose valid bit is clear reads as zero.
   logic [31:0]        hist_mem [HIST_BINS];
   logic [HIST_BINS-1:0] hist_vld_ff;
   logic [31:0]        hist_rd_ff;
   logic               hist_vld_rd_ff;
   logic               hist_rd_en;
   logic [HIST_AW-1:0] hist_rd_addr;
   logic               hist_wr_en;
   logic [31:0]        hist_val;

   lrusd_search_cmd_type search_cmd;
   lrusd_search_sts_type search_sts;

   logic [63:0] code_end;
   logic [63:0] probe;
   logic        skip;
   logic        is_access;
   logic [7:0]  hit_dist;

   // The code region test works on the low address word with the upper word
   // forced to ones, so a region end that wraps past 2^64 excludes nothing.
   assign code_end  = (HIGH_ONES | 64'(base_ff)) + 64'(size_ff);
   assign probe     = HIGH_ONES | 64'(req_ff.address[31:0]);
   assign is_access = (req_ff.opcode == OP_ACCESS);
   assign skip      = exclude_ff && (probe <= code_end);
   assign hit_dist  = clamp_dist(search_sts.depth);
   assign hist_val  = hist_vld_rd_ff ? hist_rd_ff : '0;

   lrusd_stack u_stack (
      .clock (clock),
      .reset (reset),
      .cmd   (search_cmd),
      .sts   (search_sts)
   );

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         exclude_ff <= 1'b0;
         shift_ff   <= LINE_SHIFT_RESET;
         base_ff    <= '0;
         size_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_EXCLUDE:    exclude_ff <= csr_wdata[0];
            CSR_LINE_SHIFT: shift_ff   <= csr_wdata[3:0];
            CSR_CODE_BASE:  base_ff    <= csr_wdata;
            CSR_CODE_SIZE:  size_ff    <= csr_wdata;
            default:        exclude_ff <= exclude_ff;
         endcase
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         TOP_IDLE: begin
            if (req_valid) begin
               state_in = TOP_DECODE;
            end
         end
         TOP_DECODE: begin
            if (is_access && !skip) begin
               state_in = TOP_SEARCH;
            end else if (req_ff.opcode == OP_READ) begin
               state_in = TOP_HREAD;
            end else begin
               state_in = TOP_RESP;
            end
         end
         TOP_SEARCH: begin
            if (search_sts.done) begin
               state_in = search_sts.hit ? TOP_HREAD : TOP_RESP;
            end
         end
         TOP_HREAD: state_in = TOP_RESP;
         TOP_RESP: begin
            if (rsp_load) begin
               state_in = TOP_IDLE;
            end
         end
         default: state_in = TOP_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      req_stall        = 1'b1;
      search_cmd.start = 1'b0;
      search_cmd.line  = req_ff.address & ({64{1'b1}} << shift_ff);
      hist_rd_en       = 1'b0;
      hist_rd_addr     = req_ff.bin_index;
      hist_wr_en       = 1'b0;
      rsp_load         = 1'b0;
      unique case (state_ff)
         TOP_IDLE: req_stall = 1'b0;
         TOP_DECODE: begin
            search_cmd.start = is_access && !skip;
            hist_rd_en       = (req_ff.opcode == OP_READ);
         end
         TOP_SEARCH: begin
            hist_rd_en   = search_sts.done && search_sts.hit;
            hist_rd_addr = hit_dist;
         end
         TOP_HREAD: hist_wr_en = hit_ff;
         TOP_RESP:  rsp_load   = !rsp_valid_ff || !rsp_stall;
         default:   req_stall  = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= TOP_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Transaction capture and per-transaction results.
   always_ff @(posedge clock) begin
      if (state_ff == TOP_IDLE && req_valid) begin
         req_ff   <= req_data;
         dist_ff  <= '0;
         hit_ff   <= 1'b0;
         cold_ff  <= 1'b0;
         skip_ff  <= 1'b0;
         count_ff <= '0;
      end
      if (state_ff == TOP_DECODE) begin
         skip_ff <= is_access && skip;
      end
      if (state_ff == TOP_SEARCH && search_sts.done) begin
         hit_ff  <= search_sts.hit;
         cold_ff <= !search_sts.hit;
         dist_ff <= search_sts.hit ? hit_dist : 8'd0;
      end
      if (state_ff == TOP_HREAD && req_ff.opcode == OP_READ) begin
         count_ff <= hist_val;
      end
   end

   // Running totals.
   always_ff @(posedge clock) begin
      if (reset) begin
         cold_cnt_ff   <= '0;
         access_cnt_ff <= '0;
         retire_cnt_ff <= '0;
         max_depth_ff  <= '0;
      end else begin
         if (state_ff == TOP_DECODE && req_ff.opcode == OP_RETIRE) begin
            retire_cnt_ff <= sat_inc(retire_cnt_ff);
         end
         if (state_ff == TOP_SEARCH && search_sts.done) begin
            access_cnt_ff <= sat_inc(access_cnt_ff);
            if (!search_sts.hit) begin
               cold_cnt_ff <= sat_inc(cold_cnt_ff);
            end else if (hit_dist > max_depth_ff) begin
               max_depth_ff <= hit_dist;
            end
         end
      end
   end

   // Histogram valid bits: cleared at reset, set on the first increment.
   always_ff @(posedge clock) begin
      if (reset) begin
         hist_vld_ff <= '0;
      end else if (hist_wr_en) begin
         hist_vld_ff[dist_ff] <= 1'b1;
      end
   end

   // Histogram memory: read a bin, then increment it and write it back in the next cycle.
   always_ff @(posedge clock) begin
      if (hist_wr_en) begin
         hist_mem[dist_ff] <= sat_inc(hist_val);
      end
      if (hist_rd_en) begin
         hist_rd_ff     <= hist_mem[hist_rd_addr];
         hist_vld_rd_ff <= hist_vld_ff[hist_rd_addr];
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && rsp_stall);
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff.distance      <= dist_ff;
         rsp_ff.was_hit       <= hit_ff;
         rsp_ff.was_cold      <= cold_ff;
         rsp_ff.was_skipped   <= skip_ff;
         rsp_ff.bin_count     <= count_ff;
         rsp_ff.cold_total    <= cold_cnt_ff;
         rsp_ff.access_total  <= access_cnt_ff;
         rsp_ff.retired_total <= retire_cnt_ff;
         rsp_ff.deepest_hit   <= max_depth_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ASSERT_IMPLIES(a_hit_not_cold, clock, reset, rsp_valid_ff, !(rsp_ff.was_hit && rsp_ff.was_cold), "hit and cold together")
   `ASSERT_IMPLIES(a_deepest_covers_hit, clock, reset, rsp_valid_ff && rsp_ff.was_hit, rsp_ff.deepest_hit >= rsp_ff.distance, "deepest hit below reported distance")
   `ASSERT_IMPLIES(a_result_from_resp, clock, reset, $rose(rsp_valid_ff), $past(state_ff == TOP_RESP), "result raised outside response state")

endmodule

`default_nettype wire

>>> verif/tb_lru_stack_distance_profiler.sv
module tb_lru_stack_distance_profiler
   import lrusd_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   // Clock period, the guard on run length, and the opcode that the package
   // leaves unnamed. The block must treat that opcode as a pure status read.
   localparam int          CLOCK_PERIOD = 10;
   localparam longint      CYCLE_LIMIT  = 1_000_000;
   localparam logic [1:0]  OP_UNUSED    = 2'd3;
   localparam int          PHASE_ITEMS  = 150;

   // The scoreboard keeps its own copy of the LRU stack, the histogram, the
   // running totals and the four registers. Every accepted request transaction
   // is turned into one expected result at the moment it is accepted. Results
   // are then matched in order against that list.
   class stack_distance_scoreboard;
      logic [63:0]       stack_lines [STACK_DEPTH];
      int unsigned       fill;
      logic [31:0]       hist [HIST_BINS];
      logic [31:0]       cold_n;
      logic [31:0]       access_n;
      logic [31:0]       retire_n;
      logic [7:0]        deepest;
      bit                excl;
      logic [3:0]        shift;
      logic [31:0]       base;
      logic [31:0]       size;
      lrusd_rsp_type     expected_results [$];
      int unsigned       errors;

      function new();
         foreach (hist[i]) hist[i] = '0;
         fill     = 0;
         cold_n   = '0;
         access_n = '0;
         retire_n = '0;
         deepest  = '0;
         excl     = 1'b0;
         shift    = LINE_SHIFT_RESET;
         base     = '0;
         size     = '0;
         errors   = 0;
      endfunction

      function logic [31:0] bump(input logic [31:0] v);
         return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
      endfunction

      function void write_csr(input logic [1:0] index, input logic [31:0] value);
         case (index)
            CSR_EXCLUDE:    excl  = value[0];
            CSR_LINE_SHIFT: shift = value[3:0];
            CSR_CODE_BASE:  base  = value;
            CSR_CODE_SIZE:  size  = value;
            default: ;
         endcase
      endfunction

      function void take_request(input lrusd_req_type req);
         lrusd_rsp_type r;
         logic [63:0]   code_end;
         logic [63:0]   probe;
         logic [63:0]   line_addr;
         int unsigned   pos;
         r = '0;
         case (req.opcode)
            OP_ACCESS: begin
               // The region end is formed in 64 bits and may wrap past zero.
               code_end = (HIGH_ONES | {32'd0, base}) + {32'd0, size};
               probe    = HIGH_ONES | {32'd0, req.address[31:0]};
               if (excl && probe <= code_end) begin
                  r.was_skipped = 1'b1;
               end else begin
                  line_addr = req.address & ~((64'd1 << shift) - 64'd1);
                  pos = fill;
                  for (int unsigned i = 0; i < fill && pos == fill; i++) begin
                     if (stack_lines[i] == line_addr) pos = i;
                  end
                  if (pos < fill) begin
                     r.was_hit  = 1'b1;
                     r.distance = (pos > 255) ? 8'hFF : 8'(pos);
                     if (r.distance > deepest) deepest = r.distance;
                     hist[r.distance] = bump(hist[r.distance]);
                  end else begin
                     r.was_cold = 1'b1;
                     cold_n = bump(cold_n);
                     if (fill < STACK_DEPTH) fill++;
                     pos = fill - 1;
                  end
                  for (int unsigned i = pos; i > 0; i--) stack_lines[i] = stack_lines[i - 1];
                  stack_lines[0] = line_addr;
                  access_n = bump(access_n);
               end
            end
            OP_RETIRE: retire_n = bump(retire_n);
            OP_READ:   r.bin_count = hist[req.bin_index];
            default: ;
         endcase
         r.cold_total    = cold_n;
         r.access_total  = access_n;
         r.retired_total = retire_n;
         r.deepest_hit   = deepest;
         expected_results.push_back(r);
      endfunction

      function void compare(input string field, input logic [63:0] want,
                            input logic [63:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0h, got %0h",
                     $time, field, want, got);
         end
      endfunction

      function void check_result(input lrusd_rsp_type rsp);
         lrusd_rsp_type e;
         if (expected_results.size() == 0) begin
            errors++;
            $display("%0t ns: result with nothing expected, expected none, got %0h",
                     $time, rsp);
            return;
         end
         e = expected_results.pop_front();
         compare("distance",      e.distance,      rsp.distance);
         compare("was_hit",       e.was_hit,       rsp.was_hit);
         compare("was_cold",      e.was_cold,      rsp.was_cold);
         compare("was_skipped",   e.was_skipped,   rsp.was_skipped);
         compare("bin_count",     e.bin_count,     rsp.bin_count);
         compare("cold_total",    e.cold_total,    rsp.cold_total);
         compare("access_total",  e.access_total,  rsp.access_total);
         compare("retired_total", e.retired_total, rsp.retired_total);
         compare("deepest_hit",   e.deepest_hit,   rsp.deepest_hit);
      endfunction

      function int outstanding();
         return expected_results.size();
      endfunction
   endclass

   logic          clock = 1'b0;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   lrusd_req_type req_data;
   logic          rsp_valid;
   logic          rsp_stall;
   lrusd_rsp_type rsp_data;
   logic          csr_we;
   logic [1:0]    csr_index;
   logic [31:0]   csr_wdata;

   stack_distance_scoreboard sb;

   // When calm is set, neither side inserts idle cycles. This gives a long
   // stretch of back-to-back traffic in the middle of the run.
   bit            calm = 1'b0;
   longint        cycle_count = 0;

   // Every address sent so far. Reusing entries from this log, near or far
   // back, is what produces hits at all depths and returns of evicted lines.
   logic [63:0]   addr_log [$];

   lru_stack_distance_profiler dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // The run is cut off if it takes far longer than the slowest correct run.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   // The receiver stalls at random, except during the calm stretch.
   always @(negedge clock) begin
      rsp_stall <= !calm && ($urandom_range(0, 99) < 24);
   end

   // Both channels are observed at the rising edge. A result is checked before
   // a request accepted at the same edge is noted, since that result can only
   // belong to an earlier transaction.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_data);
         if (req_valid && !req_stall) sb.take_request(req_data);
      end
   end

   // Sends one request transaction, with a random gap ahead of it. The payload
   // holds until the block accepts it.
   task automatic send(input logic [1:0] op, input logic [63:0] addr,
                       input logic [7:0] bin);
      lrusd_req_type item;
      int unsigned   gap;
      item.opcode    = op;
      item.address   = addr;
      item.bin_index = bin;
      gap = (!calm && $urandom_range(0, 99) < 24) ? $urandom_range(1, 6) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   // Stops sending and waits until every expected result has come back and
   // the block reports itself idle again.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.outstanding() != 0 || req_stall) @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [31:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      sb.write_csr(index, value);
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Registers change only while the block is idle, and all four are written
   // on every change of setting.
   task automatic configure(input bit excl, input logic [3:0] shift,
                            input logic [31:0] base, input logic [31:0] size);
      drain();
      write_csr(CSR_EXCLUDE, {31'd0, excl});
      write_csr(CSR_LINE_SHIFT, {28'd0, shift});
      write_csr(CSR_CODE_BASE, base);
      write_csr(CSR_CODE_SIZE, size);
   endtask

   // Picks the next access address. About half of them revisit an earlier
   // address with fresh offset bits inside the same line: mostly recent ones,
   // some from far back. The rest are new, and when exclusion is on many of
   // those land just above the start of the code region.
   function automatic logic [63:0] pick_address();
      logic [63:0] a;
      int unsigned roll;
      int unsigned back;
      roll = $urandom_range(0, 99);
      if (addr_log.size() != 0 && roll < 50) begin
         if (roll < 28)      back = $urandom_range(0, 7);
         else if (roll < 40) back = $urandom_range(0, 63);
         else                back = $urandom_range(0, addr_log.size() - 1);
         if (back >= addr_log.size()) back = addr_log.size() - 1;
         a = addr_log[addr_log.size() - 1 - back];
         a = a ^ ({$urandom, $urandom} & ((64'd1 << sb.shift) - 64'd1));
      end else begin
         a = {$urandom, $urandom};
         if (sb.excl && roll < 75) a[31:0] = sb.base + $urandom_range(0, 8192);
      end
      addr_log.push_back(a);
      return a;
   endfunction

   initial begin
      int unsigned roll;
      logic [1:0]  op;
      logic [7:0]  bin;

      sb        = new();
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_stall = 1'b0;
      csr_we    = 1'b0;
      csr_index = CSR_EXCLUDE;
      csr_wdata = '0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      drain();

      // Directed part, first with the register defaults (no exclusion, 64-byte
      // lines). An empty histogram is read, a retire tick and the unknown
      // opcode are sent, and a few lines are revisited at known depths,
      // including the lowest and highest addresses and an offset within a line.
      send(OP_READ,   64'd0, 8'd0);
      send(OP_RETIRE, 64'd0, 8'd0);
      send(OP_UNUSED, '1,    8'hFF);
      send(OP_ACCESS, 64'd0, 8'd0);
      send(OP_ACCESS, 64'd0, 8'd0);
      send(OP_ACCESS, 64'h3F, 8'd0);
      send(OP_ACCESS, '1,    8'd0);
      send(OP_ACCESS, 64'd0, 8'd0);
      send(OP_ACCESS, 64'h40, 8'd0);
      send(OP_ACCESS, '1,    8'd0);
      send(OP_READ,   64'd0, 8'd0);
      send(OP_READ,   64'd0, 8'd2);
      send(OP_READ,   64'd0, 8'hFF);

      // Byte-sized lines: neighboring bytes are distinct lines.
      configure(1'b0, 4'd0, 32'd0, 32'd0);
      send(OP_ACCESS, 64'd1, 8'd0);
      send(OP_ACCESS, 64'd0, 8'd0);

      // Exclusion with the widest line shift. Only the low 32 address bits
      // are compared, so an address with its high half set is still skipped.
      configure(1'b1, 4'd15, 32'h0000_1000, 32'h0000_0100);
      send(OP_ACCESS, 64'hFFFF_FFFF_0000_1080, 8'd0);
      send(OP_ACCESS, 64'h0000_0000_0000_1101, 8'd0);

      // A region whose end wraps past the top of the 64-bit range skips nothing.
      configure(1'b1, 4'd12, 32'hFFFF_FFF0, 32'h0000_0020);
      send(OP_ACCESS, 64'd0, 8'd0);
      send(OP_ACCESS, '1,    8'd0);

      // An empty region at zero still skips the address zero itself.
      configure(1'b1, 4'd6, 32'd0, 32'd0);
      send(OP_ACCESS, 64'd0, 8'd0);
      send(OP_ACCESS, 64'd1, 8'd0);

      // The largest region ends at the top of the range and skips everything.
      configure(1'b1, 4'd6, 32'd0, 32'hFFFF_FFFF);
      send(OP_ACCESS, {$urandom, $urandom}, 8'd0);

      // Random part in four phases with different settings. The third phase
      // runs with no idle cycles on either side.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: configure(1'b0, 4'd6, $urandom, $urandom);
            1: configure(1'b1, 4'($urandom_range(0, 15)), $urandom,
                         $urandom_range(0, 1 << 20));
            2: configure(1'b0, 4'd12, $urandom, $urandom);
            default: configure(1'b1, 4'd0, $urandom, $urandom);
         endcase
         calm = (phase == 2);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 72)      op = OP_ACCESS;
            else if (roll < 84) op = OP_READ;
            else if (roll < 96) op = OP_RETIRE;
            else                op = OP_UNUSED;
            // Most histogram reads go to the shallow bins where counts build up.
            bin = ($urandom_range(0, 99) < 60) ? 8'($urandom_range(0, 15))
                                               : 8'($urandom_range(0, 255));
            if (op == OP_ACCESS) send(op, pick_address(), bin);
            else                 send(op, {$urandom, $urandom}, bin);
         end
      end
      calm = 1'b0;

      // Wait for the last results, then watch a while longer for any stray
      // result transaction.
      drain();
      repeat (STACK_DEPTH + 16) @(posedge clock);

      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/lrusd_pkg.sv
rtl/core/lrusd_stack.sv
rtl/core/lru_stack_distance_profiler.sv
verif/tb_lru_stack_distance_profiler.sv
